// ----- design/mmp_pkg.sv -----
// Package with the word types and fixed constants of the mecanum mixer.
`default_nettype none

package mmp_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int VEL_W      = 16;
  localparam int WHEEL_W    = 18;
  localparam int MAG_W      = 17;
  localparam int DUTY_W     = 8;

  localparam logic [MAG_W-1:0]  FULL_SCALE = MAG_W'(25600);
  localparam logic [DUTY_W-1:0] DUTY_MAX   = '1;

  localparam int WH_FL = 0;
  localparam int WH_FR = 1;
  localparam int WH_BL = 2;
  localparam int WH_BR = 3;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_rot;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_front_left;
    logic [DUTY_W-1:0] duty_front_right;
    logic [DUTY_W-1:0] duty_back_left;
    logic [DUTY_W-1:0] duty_back_right;
    logic              pin_front_left;
    logic              pin_front_right;
    logic              pin_back_left;
    logic              pin_back_right;
  } out_word_t;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]                 denom;
    logic [NUM_WHEELS-1:0]            pin;
  } mix_word_t;

endpackage

`default_nettype wire

// ----- design/mmp_mix.sv -----
// Three-stage front end: wheel mix, magnitudes and pins, normalizing denominator.
`default_nettype none

module mmp_mix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire mmp_pkg::in_word_t  up_word,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output mmp_pkg::mix_word_t      dn_word
);
  import mmp_pkg::*;

  logic                      v1_r, v2_r, v3_r;
  logic                      en1, en2, en3;
  logic signed [WHEEL_W-1:0] w_r [NUM_WHEELS];
  logic signed [WHEEL_W-1:0] x_s, y_s, r_s;
  logic [NUM_WHEELS-1:0][MAG_W-1:0] mag2_r;
  logic [NUM_WHEELS-1:0]     pin2_r;
  mix_word_t                 word3_r;
  logic [MAG_W-1:0]          max01, max23, max4, denom_nxt;

  // A stage takes a new word when it is empty or its successor moves.
  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  assign x_s = WHEEL_W'(up_word.vel_x);
  assign y_s = WHEEL_W'(up_word.vel_y);
  assign r_s = WHEEL_W'(up_word.vel_rot);

  always_comb begin
    max01     = (mag2_r[0] > mag2_r[1]) ? mag2_r[0] : mag2_r[1];
    max23     = (mag2_r[2] > mag2_r[3]) ? mag2_r[2] : mag2_r[3];
    max4      = (max01 > max23) ? max01 : max23;
    denom_nxt = (max4 > FULL_SCALE) ? max4 : FULL_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      w_r[WH_FL] <= y_s + x_s - r_s;
      w_r[WH_FR] <= y_s - x_s + r_s;
      w_r[WH_BL] <= y_s - x_s - r_s;
      w_r[WH_BR] <= y_s + x_s + r_s;
    end
    if (en2 && v1_r) begin
      for (int l = 0; l < NUM_WHEELS; l++) begin
        mag2_r[l] <= w_r[l][WHEEL_W-1] ? MAG_W'(-w_r[l]) : MAG_W'(w_r[l]);
      end
      // Left pins flag reverse; right pins flag forward or stopped.
      pin2_r[WH_FL] <= w_r[WH_FL][WHEEL_W-1];
      pin2_r[WH_FR] <= !w_r[WH_FR][WHEEL_W-1];
      pin2_r[WH_BL] <= w_r[WH_BL][WHEEL_W-1];
      pin2_r[WH_BR] <= !w_r[WH_BR][WHEEL_W-1];
    end
    if (en3 && v2_r) begin
      word3_r.mag   <= mag2_r;
      word3_r.pin   <= pin2_r;
      word3_r.denom <= denom_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_word  = word3_r;

endmodule

`default_nettype wire

// ----- design/mmp_scale.sv -----
// Ten-stage back end: duty multiply, saturation check and an 8-stage divider per wheel.
`default_nettype none

module mmp_scale #(
  parameter int DUTY_FULL = 255
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire mmp_pkg::mix_word_t up_word,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output mmp_pkg::out_word_t      dn_word
);
  import mmp_pkg::*;

  localparam int FW  = $clog2(DUTY_FULL + 1);
  localparam int NW  = FW + MAG_W;
  localparam int RW  = NW + DUTY_W;
  localparam int NST = DUTY_W + 2;

  logic [NST-1:0]          v_r;
  logic [NST-1:0]          en;
  logic [RW-1:0]           rem_r [NST][NUM_WHEELS];
  logic [DUTY_W-1:0]       quo_r [NST][NUM_WHEELS];
  logic [NUM_WHEELS-1:0]   sat_r [NST];
  logic [MAG_W-1:0]        den_r [NST];
  logic [NUM_WHEELS-1:0]   pin_r [NST];
  logic [NW-1:0]           prod  [NUM_WHEELS];
  logic [DUTY_W-1:0]       duty  [NUM_WHEELS];

  always_comb begin
    en[NST-1] = !v_r[NST-1] || dn_ready;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end
  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= up_valid;
      for (int s = 1; s < NST; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_WHEELS; l++) begin
      prod[l] = NW'(up_word.mag[l]) * NW'(DUTY_FULL);
    end
  end

  // Stage 0: numerator DUTY_FULL times magnitude.
  always_ff @(posedge clk) begin
    if (en[0] && up_valid) begin
      for (int l = 0; l < NUM_WHEELS; l++) begin
        rem_r[0][l] <= RW'(prod[l]);
        quo_r[0][l] <= '0;
      end
      sat_r[0] <= '0;
      den_r[0] <= up_word.denom;
      pin_r[0] <= up_word.pin;
    end
  end

  // Stage 1: a quotient of 256 or more saturates to the full duty code.
  always_ff @(posedge clk) begin
    if (en[1] && v_r[0]) begin
      for (int l = 0; l < NUM_WHEELS; l++) begin
        rem_r[1][l] <= rem_r[0][l];
        quo_r[1][l] <= quo_r[0][l];
        sat_r[1][l] <= rem_r[0][l] >= (RW'(den_r[0]) << DUTY_W);
      end
      den_r[1] <= den_r[0];
      pin_r[1] <= pin_r[0];
    end
  end

  // Restoring division, one quotient bit per stage from the top bit down.
  for (genvar s = 2; s < NST; s++) begin : g_div
    localparam int K = NST - 1 - s;
    logic [RW-1:0]     rem_nxt [NUM_WHEELS];
    logic [DUTY_W-1:0] quo_nxt [NUM_WHEELS];
    logic [RW-1:0]     dsh;

    always_comb begin
      dsh = RW'(den_r[s-1]) << K;
      for (int l = 0; l < NUM_WHEELS; l++) begin
        rem_nxt[l] = rem_r[s-1][l];
        quo_nxt[l] = quo_r[s-1][l];
        if (rem_r[s-1][l] >= dsh) begin
          rem_nxt[l]    = rem_r[s-1][l] - dsh;
          quo_nxt[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s] && v_r[s-1]) begin
        for (int l = 0; l < NUM_WHEELS; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          quo_r[s][l] <= quo_nxt[l];
        end
        sat_r[s] <= sat_r[s-1];
        den_r[s] <= den_r[s-1];
        pin_r[s] <= pin_r[s-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_WHEELS; l++) begin
      duty[l] = sat_r[NST-1][l] ? DUTY_MAX : quo_r[NST-1][l];
    end
  end

  assign dn_valid                 = v_r[NST-1];
  assign dn_word.duty_front_left  = duty[WH_FL];
  assign dn_word.duty_front_right = duty[WH_FR];
  assign dn_word.duty_back_left   = duty[WH_BL];
  assign dn_word.duty_back_right  = duty[WH_BR];
  assign dn_word.pin_front_left   = pin_r[NST-1][WH_FL];
  assign dn_word.pin_front_right  = pin_r[NST-1][WH_FR];
  assign dn_word.pin_back_left    = pin_r[NST-1][WH_BL];
  assign dn_word.pin_back_right   = pin_r[NST-1][WH_BR];

endmodule

`default_nettype wire

// ----- design/mecanum_mixer_pwm_core.sv -----
// Throughput: one word per cycle while out_ready is high.
// The 8-stage divider pipeline sets the depth, not the rate.
// Each stage advances when empty or when its successor moves, so bubbles are squeezed out
// and a stalled output still lets the front stages fill.
// Reset clears only the stage valid bits; no clearing pass, input is ready right after reset.
`default_nettype none

module mecanum_mixer_pwm_core #(
  parameter int DUTY_FULL = 255
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mmp_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mmp_pkg::out_word_t       out_word
);
  import mmp_pkg::*;

  logic      mix_valid;
  logic      mix_ready;
  mix_word_t mix_word;

  mmp_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_word  (in_word),
    .dn_valid (mix_valid),
    .dn_ready (mix_ready),
    .dn_word  (mix_word)
  );

  mmp_scale #(
    .DUTY_FULL (DUTY_FULL)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mix_valid),
    .up_ready (mix_ready),
    .up_word  (mix_word),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_word  (out_word)
  );

endmodule

`default_nettype wire

// ----- design/mmp_checker.sv -----
// Port-level checker for the mecanum mixer core and its bind.
`default_nettype none

module mmp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire mmp_pkg::in_word_t  in_word,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mmp_pkg::out_word_t out_word
);
  import mmp_pkg::*;

  localparam int DEPTH = 13;

  logic [4:0] inflight_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 5'(in_acc) - 5'(out_acc);
    end
  end

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 5'd0)
    else $error("result word shown with no word in flight");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 5'(DEPTH))
    else $error("more words in flight than pipeline stages");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed or dropped");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_word))
    else $error("waiting input word changed or dropped");

endmodule

bind mecanum_mixer_pwm_core mmp_checker u_mmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
